FILE: rtl/lrg_pkg.sv
// Shared types and constants for the linear ramp generator.
// Holds function codes, register indexes, state encoding and fixed widths.
// No dependencies.
package lrg_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF  = 24;
    localparam int FRAC_BITS       = 16;
    localparam int GRAIN_WIDTH     = 16;
    localparam int FUNC_WIDTH      = 3;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [GRAIN_WIDTH-1:0] DEFAULT_GRAIN = GRAIN_WIDTH'(20);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GRAIN    = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INT_MODE = CFG_INDEX_WIDTH'(1);

    typedef enum logic [FUNC_WIDTH-1:0] {
        FN_GO        = 3'd0,
        FN_SET       = 3'd1,
        FN_STOP      = 3'd2,
        FN_TICK      = 3'd3,
        FN_RAMP_TIME = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_STEPS,
        ST_DIV_SIZE,
        ST_START
    } t_state;

endpackage

FILE: rtl/lrg_divider.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Shared by the step count and step size computations of the ramp generator.
// No package dependencies.
module lrg_divider #(
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_div;

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign ge     = !diff[DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                r_quo <= {r_quo[DW-2:0], ge};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/linear_ramp_generator.sv
// Linear ramp generator: a go request with a pending ramp time starts a ramp after two
// passes through the shared one-bit-per-cycle divider, first for the step count, then
// for the step size, with DW = max(VALUE_WIDTH+1, TIME_WIDTH); set, stop, tick,
// ramp-time and other go requests take no divider pass.
// One request is in work at a time; o_stall stays high until it is done.
// Synchronous active-low reset: ramp idle, goal, current, step and pending time zero, grain 20, integer mode on.
module linear_ramp_generator
    import lrg_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [FUNC_WIDTH-1:0]      i_func,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic signed [TIME_WIDTH-1:0]  i_ramp_time,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_level,
    output logic                       o_reached,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int TW = TIME_WIDTH;
    localparam int DW = (VW + 1 > TW) ? VW + 1 : TW;
    localparam logic [VW-1:0] FRAC_MASK = {VW{1'b1}} >> (VW - FRAC_BITS);

    t_state r_state, n_state;

    logic [VW-1:0]          r_goal;
    logic [VW-1:0]          r_current;
    logic [VW-1:0]          r_step;
    logic [TW-1:0]          r_steps_left;
    logic [TW-1:0]          r_pending;
    logic                   r_running;
    logic [GRAIN_WIDTH-1:0] r_countdown;
    logic [GRAIN_WIDTH-1:0] r_grain;
    logic                   r_int_mode;

    logic [FUNC_WIDTH-1:0]  r_func;
    logic [VW-1:0]          r_value;
    logic [TW-1:0]          r_time;
    logic [VW-1:0]          r_start;
    logic [VW-1:0]          r_dist_mag;
    logic                   r_dist_neg;

    logic                   r_out_valid;
    logic [VW-1:0]          r_out_level;
    logic                   r_out_reached;

    logic                   div_start;
    logic                   div_done;
    logic [DW-1:0]          div_dividend;
    logic [DW-1:0]          div_divisor;
    logic [DW-1:0]          div_quotient;

    logic                   out_free;
    logic                   pending_set;
    logic                   tick_fires;
    logic [GRAIN_WIDTH-1:0] grain_now;
    logic [VW-1:0]          start_sel;
    logic [VW:0]            delta;
    logic [VW:0]            dist_abs;
    logic [TW-1:0]          steps_calc;
    logic [VW:0]            step_mag;
    logic [VW:0]            step_full;
    logic [VW-1:0]          step_sat;

    logic                   emit_go;
    logic                   ramp_commit;
    logic [VW-1:0]          base_val;
    logic [VW-1:0]          goal_sel;
    logic [TW-1:0]          steps_next;
    logic [VW:0]            sum_full;
    logic [VW-1:0]          sum_sat;
    logic                   emit_en;
    logic [VW-1:0]          emit_val;
    logic                   emit_reached;
    logic [VW-1:0]          emit_round;

    function automatic logic [VW-1:0] sat_val(input logic [VW:0] x);
        if (x[VW] != x[VW-1]) begin
            sat_val = x[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            sat_val = x[VW-1:0];
        end
    endfunction

    assign out_free    = !r_out_valid || !i_stall;
    assign pending_set = (r_pending != '0);
    assign tick_fires  = r_running && (r_countdown <= GRAIN_WIDTH'(1));
    assign grain_now   = (r_grain == '0) ? DEFAULT_GRAIN : r_grain;
    assign start_sel   = r_running ? r_current : r_goal;
    assign delta       = {r_value[VW-1], r_value} - {start_sel[VW-1], start_sel};
    assign dist_abs    = delta[VW] ? -delta : delta;
    assign steps_calc  = div_quotient[TW-1:0] + TW'(1);
    assign step_mag    = div_quotient[VW:0];
    assign step_full   = r_dist_neg ? -step_mag : step_mag;
    assign step_sat    = sat_val(step_full);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (r_func)
                    FN_GO: begin
                        if (pending_set) n_state = ST_DIV_STEPS;
                        else if (out_free) n_state = ST_IDLE;
                    end
                    FN_TICK: begin
                        if (!tick_fires || out_free) n_state = ST_IDLE;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_DIV_STEPS: begin
                if (div_done) n_state = ST_DIV_SIZE;
            end
            ST_DIV_SIZE: begin
                if (div_done) n_state = ST_START;
            end
            ST_START: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = DW'(r_dist_mag);
        div_divisor  = DW'(steps_calc);
        emit_go      = 1'b0;
        ramp_commit  = 1'b0;
        case (r_state)
            ST_EXEC: begin
                div_dividend = DW'(r_pending - TW'(1));
                div_divisor  = DW'(grain_now);
                if (r_func == FN_GO) begin
                    div_start = pending_set;
                    emit_go   = !pending_set && out_free;
                end
                if (r_func == FN_TICK) ramp_commit = tick_fires && out_free;
            end
            ST_DIV_STEPS: div_start   = div_done;
            ST_START:     ramp_commit = out_free;
            default: ;
        endcase
    end

    assign base_val   = (r_state == ST_START) ? r_start : r_current;
    assign goal_sel   = (r_state == ST_START) ? r_value : r_goal;
    assign steps_next = r_steps_left - TW'(r_steps_left != '0);
    assign sum_full   = {base_val[VW-1], base_val} + {r_step[VW-1], r_step};
    assign sum_sat    = sat_val(sum_full);

    always_comb begin
        emit_en      = emit_go || ramp_commit;
        emit_val     = r_value;
        emit_reached = 1'b1;
        if (ramp_commit) begin
            if (steps_next != '0) begin
                emit_val     = sum_sat;
                emit_reached = 1'b0;
            end else begin
                emit_val = goal_sel;
            end
        end
    end

    assign emit_round = (emit_val + (emit_val[VW-1] ? FRAC_MASK : '0)) & ~FRAC_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_goal        <= '0;
            r_current     <= '0;
            r_step        <= '0;
            r_steps_left  <= '0;
            r_pending     <= '0;
            r_running     <= 1'b0;
            r_countdown   <= '0;
            r_grain       <= DEFAULT_GRAIN;
            r_int_mode    <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GRAIN) r_grain <= i_cfg_data[GRAIN_WIDTH-1:0];
                if (i_cfg_index == CFG_INT_MODE) r_int_mode <= i_cfg_data[0];
            end
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;

            if (r_state == ST_IDLE && i_valid) begin
                r_func  <= i_func;
                r_value <= i_value;
                r_time  <= i_ramp_time;
            end

            if (r_state == ST_EXEC) begin
                case (r_func)
                    FN_GO: begin
                        if (pending_set) begin
                            r_start    <= start_sel;
                            r_dist_neg <= delta[VW];
                            r_dist_mag <= dist_abs[VW-1:0];
                        end else if (out_free) begin
                            r_goal       <= r_value;
                            r_steps_left <= '0;
                            r_running    <= 1'b0;
                            r_countdown  <= '0;
                        end
                    end
                    FN_SET: begin
                        r_goal       <= r_value;
                        r_steps_left <= '0;
                        r_running    <= 1'b0;
                        r_countdown  <= '0;
                    end
                    FN_STOP: begin
                        r_goal       <= r_current;
                        r_steps_left <= '0;
                        r_running    <= 1'b0;
                        r_countdown  <= '0;
                    end
                    FN_TICK: begin
                        if (r_running && !tick_fires) r_countdown <= r_countdown - GRAIN_WIDTH'(1);
                    end
                    FN_RAMP_TIME: r_pending <= r_time[TW-1] ? '0 : r_time;
                    default: ;
                endcase
            end

            if (r_state == ST_DIV_STEPS && div_done) r_steps_left <= steps_calc;
            if (r_state == ST_DIV_SIZE && div_done) r_step <= step_sat;

            if (ramp_commit) begin
                r_steps_left <= steps_next;
                if (r_state == ST_START) begin
                    r_goal    <= r_value;
                    r_pending <= '0;
                end
                if (steps_next != '0) begin
                    r_current   <= sum_sat;
                    r_countdown <= grain_now;
                    r_running   <= 1'b1;
                end else begin
                    r_current   <= base_val;
                    r_countdown <= '0;
                    r_running   <= 1'b0;
                end
            end

            if (emit_en) begin
                r_out_valid   <= 1'b1;
                r_out_level   <= r_int_mode ? emit_round : emit_val;
                r_out_reached <= emit_reached;
            end
        end
    end

    lrg_divider #(
        .DW(DW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_level     = r_out_level;
    assign o_reached   = r_out_reached;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: rtl/lrg_checker.sv
// Port-level checks for the linear ramp generator, bound to the top level.
// Depends on lrg_pkg and on linear_ramp_generator port names.
module lrg_checker
    import lrg_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [VALUE_WIDTH-1:0] o_level,
    input logic                   o_reached
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_level) && $stable(o_reached))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted without going busy");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared with no request in work");

endmodule

bind linear_ramp_generator lrg_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_lrg_checker (.*);
